[design/pfa_pkg.sv]
// Shared constants, codes and a helper function for the page frame allocator.
// Imported by page_frame_allocator_unit and its port checker.
package pfa_pkg;

    localparam int DEF_BITMAP_PAGES     = 16384;
    localparam int DEF_STACK_DEPTH      = 1024;
    localparam int DEF_PAGE_NUMBER_BITS = 36;
    localparam int WORD_BITS            = 64;
    localparam int COUNT_W              = 15;
    localparam int CFG_INDEX_W          = 2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_PAGES    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BOUNDARY = 2'd1;

    localparam logic [COUNT_W-1:0] RST_PAGES    = 15'd16384;
    localparam int                 RST_BOUNDARY = 16384;

    // index of lowest set bit, 64 when none
    function automatic logic [6:0] tz64(input logic [WORD_BITS-1:0] v);
        logic [6:0] r;
        r = 7'd64;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = 7'(i);
            end
        end
        return r;
    endfunction

endpackage

[design/page_frame_allocator_unit.sv]
// Page frame allocator top level: bitmap memory, high-page stack memory,
// run scanner and mark sequencer. Depends on pfa_pkg.
//
// Usage:
//   Request channel (req_valid/req_ready): action 0 allocates page_count
//   contiguous pages, action 1 frees page_count pages at page_number.
//   Response channel (rsp_valid/rsp_ready): one beat per request with status
//   and granted_page. Config channel (cfg_valid/cfg_ready) is always ready:
//   index 0 sets the tracked page count, index 1 the stack boundary page.
//   Sequencing: a stack push, an ignored free or an early reject goes
//   straight to the response state; a stack pop passes S_POP first. A bitmap
//   scan reads one word per step through the single shift/priority unit, a
//   read (S_SRD) then an evaluate (S_SEV); a step ends at each change between
//   free and used pages or at a word edge. Marking or freeing a run then
//   reads (S_MRD) and writes back (S_MWR) each 64-bit word in turn.
//   req_ready is high only while the sequencer is idle; one request at a time.
//   Reset: all pages read as used, pointer and stack fill cleared. A clearing
//   pass writes zero to every bitmap word, one per cycle, before the first
//   request is taken.
//   Stall: a finished response sits in the output register; the next request
//   is accepted meanwhile and its result waits until that beat is taken.
module page_frame_allocator_unit #(
    parameter int BITMAP_PAGES     = pfa_pkg::DEF_BITMAP_PAGES,
    parameter int STACK_DEPTH      = pfa_pkg::DEF_STACK_DEPTH,
    parameter int PAGE_NUMBER_BITS = pfa_pkg::DEF_PAGE_NUMBER_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic                                action,
    input  logic [PAGE_NUMBER_BITS-1:0]         page_number,
    input  logic [pfa_pkg::COUNT_W-1:0]         page_count,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic [1:0]                          status,
    output logic [PAGE_NUMBER_BITS-1:0]         granted_page,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pfa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [PAGE_NUMBER_BITS-1:0]         cfg_data
);
    import pfa_pkg::*;

    localparam int PNB   = PAGE_NUMBER_BITS;
    localparam int PW    = $clog2(BITMAP_PAGES + 1);
    localparam int WORDS = (BITMAP_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FW    = $clog2(STACK_DEPTH + 1);
    localparam int SAW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int EW    = ((PNB > PW) ? PNB : PW) + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_SRD   = 3'd3;
    localparam logic [2:0] S_SEV   = 3'd4;
    localparam logic [2:0] S_MRD   = 3'd5;
    localparam logic [2:0] S_MWR   = 3'd6;
    localparam logic [2:0] S_RESP  = 3'd7;

    localparam logic [PW-1:0]  BP_PW   = PW'(BITMAP_PAGES);
    localparam logic [EW-1:0]  BP_EW   = EW'(BITMAP_PAGES);
    localparam logic [AW-1:0]  LAST_WD = AW'(WORDS - 1);
    localparam logic [FW-1:0]  DEPTH_F = FW'(STACK_DEPTH);

    logic [WORD_BITS-1:0] bm_mem [WORDS];
    logic [PNB-1:0]       stk_mem [STACK_DEPTH];

    logic [2:0]           state_reg, state_next;
    logic [PW-1:0]        p_reg, p_next;
    logic [PW-1:0]        run_reg, run_next;
    logic [PW-1:0]        hi_reg, hi_next;
    logic                 passb_reg, passb_next;
    logic [PW-1:0]        q_reg, q_next;
    logic [PW-1:0]        end_reg, end_next;
    logic                 setop_reg, setop_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [PW-1:0]        rp_reg, rp_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [1:0]           res_status_reg, res_status_next;
    logic [PNB-1:0]       res_page_reg, res_page_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic [PNB-1:0]       out_page_reg, out_page_next;
    logic [COUNT_W-1:0]   cfg_pages_reg;
    logic [PNB-1:0]       cfg_bound_reg;

    logic [WORD_BITS-1:0] bm_rdata_reg;
    logic [PNB-1:0]       stk_rdata_reg;
    logic                 bm_we;
    logic [AW-1:0]        bm_waddr, bm_raddr;
    logic [WORD_BITS-1:0] bm_wdata;
    logic                 stk_we;

    logic                 accept;
    logic [EW-1:0]        cfg_ext, page_ext, pend_ext, cnt_ext;
    logic [PW-1:0]        lim, pclip, eclip;
    logic [5:0]           p_off, q_off;
    logic [WORD_BITS-1:0] sh, lowmask, mask;
    logic [6:0]           room_w, avail, adv_raw, adv, mroom, n_bits;
    logic [PW-1:0]        rem_lim, start_c, mrem;
    logic [PW:0]          new_run;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    assign rsp_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign granted_page = out_page_reg;

    always_comb
    begin
        cfg_ext  = EW'(cfg_pages_reg);
        lim      = (cfg_ext > BP_EW) ? BP_PW : PW'(cfg_ext);
        page_ext = EW'(page_number);
        cnt_ext  = EW'(page_count);
        pend_ext = page_ext + cnt_ext;
        pclip    = (page_ext > BP_EW) ? BP_PW : PW'(page_ext);
        eclip    = (pend_ext > BP_EW) ? BP_PW : PW'(pend_ext);

        p_off   = p_reg[5:0];
        sh      = bm_rdata_reg >> p_off;
        room_w  = 7'd64 - {1'b0, p_off};
        rem_lim = lim - p_reg;
        avail   = (rem_lim < PW'(room_w)) ? 7'(rem_lim) : room_w;
        adv_raw = sh[0] ? tz64(~sh) : tz64(sh);
        adv     = (adv_raw < avail) ? adv_raw : avail;
        start_c = p_reg - run_reg;
        new_run = {1'b0, run_reg} + (PW + 1)'(adv);

        q_off   = q_reg[5:0];
        mroom   = 7'd64 - {1'b0, q_off};
        mrem    = end_reg - q_reg;
        n_bits  = (mrem < PW'(mroom)) ? 7'(mrem) : mroom;
        lowmask = (n_bits == 7'd64) ? '1 : ((64'd1 << n_bits) - 64'd1);
        mask    = lowmask << q_off;
    end

    always_comb
    begin
        state_next      = state_reg;
        p_next          = p_reg;
        run_next        = run_reg;
        hi_next         = hi_reg;
        passb_next      = passb_reg;
        q_next          = q_reg;
        end_next        = end_reg;
        setop_next      = setop_reg;
        cnt_next        = cnt_reg;
        rp_next         = rp_reg;
        fill_next       = fill_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_status_next = out_status_reg;
        out_page_next   = out_page_reg;
        bm_we           = 1'b0;
        bm_waddr        = clr_reg;
        bm_wdata        = '0;
        bm_raddr        = AW'(p_reg >> 6);
        stk_we          = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                bm_we    = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_WD)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_OK;
                    res_page_next   = '0;
                    cnt_next        = page_count;
                    state_next      = S_RESP;
                    if (!action)
                    begin
                        if (page_count == '0)
                        begin
                            res_status_next = ST_NOFIT;
                        end
                        else if (page_count == COUNT_W'(1) && fill_reg != '0)
                        begin
                            fill_next  = fill_reg - 1'b1;
                            state_next = S_POP;
                        end
                        else if (cnt_ext > EW'(lim))
                        begin
                            res_status_next = ST_NOFIT;
                        end
                        else if (rp_reg < lim)
                        begin
                            p_next     = rp_reg;
                            run_next   = '0;
                            hi_next    = lim - PW'(page_count) + 1'b1;
                            passb_next = 1'b0;
                            state_next = S_SRD;
                        end
                        else if (rp_reg != '0)
                        begin
                            p_next     = '0;
                            run_next   = '0;
                            hi_next    = rp_reg;
                            passb_next = 1'b1;
                            state_next = S_SRD;
                        end
                        else
                        begin
                            res_status_next = ST_NOFIT;
                        end
                    end
                    else if (page_number != '0)
                    begin
                        if (page_count == COUNT_W'(1) && page_number >= cfg_bound_reg)
                        begin
                            if (fill_reg >= DEPTH_F)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                stk_we    = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            rp_next    = pclip;
                            q_next     = pclip;
                            end_next   = eclip;
                            setop_next = 1'b1;
                            if (pclip < eclip)
                            begin
                                state_next = S_MRD;
                            end
                        end
                    end
                end
            end
            S_POP:
            begin
                res_page_next = stk_rdata_reg;
                state_next    = S_RESP;
            end
            S_SRD:
            begin
                state_next = S_SEV;
            end
            S_SEV:
            begin
                if (p_reg >= lim || start_c >= hi_reg)
                begin
                    if (!passb_reg && rp_reg != '0)
                    begin
                        p_next     = '0;
                        run_next   = '0;
                        hi_next    = rp_reg;
                        passb_next = 1'b1;
                        state_next = S_SRD;
                    end
                    else
                    begin
                        res_status_next = ST_NOFIT;
                        state_next      = S_RESP;
                    end
                end
                else if (sh[0] && new_run >= (PW + 1)'(cnt_reg))
                begin
                    q_next        = start_c;
                    end_next      = start_c + PW'(cnt_reg);
                    rp_next       = start_c + PW'(cnt_reg);
                    setop_next    = 1'b0;
                    res_page_next = PNB'(EW'(start_c));
                    state_next    = S_MRD;
                end
                else
                begin
                    p_next     = p_reg + PW'(adv);
                    run_next   = sh[0] ? PW'(new_run) : '0;
                    state_next = S_SRD;
                end
            end
            S_MRD:
            begin
                bm_raddr   = AW'(q_reg >> 6);
                state_next = S_MWR;
            end
            S_MWR:
            begin
                bm_we    = 1'b1;
                bm_waddr = AW'(q_reg >> 6);
                bm_wdata = setop_reg ? (bm_rdata_reg | mask) : (bm_rdata_reg & ~mask);
                q_next   = q_reg + PW'(n_bits);
                if (q_reg + PW'(n_bits) >= end_reg)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_MRD;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_page_next   = res_page_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        bm_rdata_reg <= bm_mem[bm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[fill_reg[SAW-1:0]] <= page_number;
        end
        stk_rdata_reg <= stk_mem[SAW'(fill_reg - 1'b1)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            rp_reg        <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            cfg_pages_reg <= RST_PAGES;
            cfg_bound_reg <= PNB'(RST_BOUNDARY);
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rp_reg        <= rp_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_PAGES:
                    begin
                        cfg_pages_reg <= cfg_data[COUNT_W-1:0];
                    end
                    CFG_BOUNDARY:
                    begin
                        cfg_bound_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg          <= p_next;
        run_reg        <= run_next;
        hi_reg         <= hi_next;
        passb_reg      <= passb_next;
        q_reg          <= q_next;
        end_reg        <= end_next;
        setop_reg      <= setop_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        out_status_reg <= out_status_next;
        out_page_reg   <= out_page_next;
    end

endmodule

[design/pfa_checker.sv]
// Port-level checker for page_frame_allocator_unit, bound to the top level.
// Depends on pfa_pkg for status codes.
module pfa_checker #(
    parameter int PAGE_NUMBER_BITS = pfa_pkg::DEF_PAGE_NUMBER_BITS
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [1:0]                  status,
    input logic [PAGE_NUMBER_BITS-1:0] granted_page
);
    import pfa_pkg::*;

    // response beat holds while stalled
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(granted_page))
        else $error("response changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == ST_OK || status == ST_NOFIT || status == ST_FULL))
        else $error("bad status code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |-> granted_page == '0)
        else $error("page granted on failure");

    // an accepted request takes the sequencer out of the idle state
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready right after a request beat");

endmodule

bind page_frame_allocator_unit pfa_checker #(
    .PAGE_NUMBER_BITS(PAGE_NUMBER_BITS)
) u_pfa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .status      (status),
    .granted_page(granted_page)
);

[bench/page_frame_allocator_unit_tb.sv]
// Self-checking bench for page_frame_allocator_unit: queued request driver,
// response monitor and an internal bitmap/stack predictor. Depends on pfa_pkg.
`timescale 1ns / 100ps

module page_frame_allocator_unit_tb;
    import pfa_pkg::*;

    localparam int  NPAGES    = DEF_BITMAP_PAGES;
    localparam int  NSTACK    = DEF_STACK_DEPTH;
    localparam int  PNB       = DEF_PAGE_NUMBER_BITS;
    localparam longint LIMIT  = 40_000_000;
    localparam logic [PNB-1:0] PAGE_MAX = '1;

    typedef struct {
        logic           act;
        logic [PNB-1:0] page;
        logic [14:0]    count;
        bit             drain;
    } pfa_req_t;

    typedef struct {
        logic [1:0]     st;
        logic [PNB-1:0] granted;
    } pfa_rsp_t;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    logic           action;
    logic [PNB-1:0] page_number;
    logic [14:0]    page_count;
    logic           rsp_valid;
    logic           rsp_ready;
    logic [1:0]     status;
    logic [PNB-1:0] granted_page;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [1:0]     cfg_index;
    logic [PNB-1:0] cfg_data;

    page_frame_allocator_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready),
        .action(action), .page_number(page_number), .page_count(page_count),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
        .status(status), .granted_page(granted_page),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    bit             pg_free [NPAGES];
    longint         rover;
    logic [PNB-1:0] hi_stack [NSTACK];
    int             hi_fill;
    logic [14:0]    tracked_pages;
    logic [PNB-1:0] boundary;

    pfa_req_t pending_reqs[$];
    pfa_rsp_t expected_rsps[$];
    int       errors;
    int       issued;
    int       accepted;
    longint   cycles;
    int       burst_left;
    int       gap_left;
    int       gap_max;
    int       stall_pct;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = 1'b1;
            #4 clk = 1'b0;
        end
    end

    task automatic report(input string what, input logic [PNB-1:0] got,
                          input logic [PNB-1:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    function automatic bit find_run(input longint lo, input longint start_hi,
                                    input longint lim, input longint cnt,
                                    output longint start);
        longint run;
        run = 0;
        start = 0;
        for (longint p = lo; p < lim; p++)
        begin
            if (p - lo >= cnt && p - cnt + 1 >= start_hi)
                return 1'b0;
            if (p < NPAGES && pg_free[p])
            begin
                run++;
                if (run == cnt)
                begin
                    start = p - cnt + 1;
                    return start < start_hi;
                end
            end
            else
            begin
                run = 0;
            end
        end
        return 1'b0;
    endfunction

    function automatic pfa_rsp_t allocate_or_free(input logic act,
                                                  input logic [PNB-1:0] page,
                                                  input logic [14:0] count);
        pfa_rsp_t r;
        longint   lim;
        longint   start;
        bit       found;
        r.st = ST_OK;
        r.granted = '0;
        lim = (tracked_pages > NPAGES) ? NPAGES : tracked_pages;
        found = 1'b0;
        if (act == 1'b0)
        begin
            if (count == 0)
                r.st = ST_NOFIT;
            else if (count == 1 && hi_fill > 0)
            begin
                hi_fill--;
                r.granted = hi_stack[hi_fill];
            end
            else if (count > lim)
                r.st = ST_NOFIT;
            else
            begin
                if (rover < lim)
                    found = find_run(rover, lim - count + 1, lim, count, start);
                if (!found)
                    found = find_run(0, rover, lim, count, start);
                if (found)
                begin
                    for (longint i = 0; i < count; i++)
                        pg_free[start + i] = 1'b0;
                    rover = start + count;
                    r.granted = start[PNB-1:0];
                end
                else
                begin
                    r.st = ST_NOFIT;
                end
            end
        end
        else if (page != 0)
        begin
            if (count == 1 && page >= boundary)
            begin
                if (hi_fill >= NSTACK)
                    r.st = ST_FULL;
                else
                begin
                    hi_stack[hi_fill] = page;
                    hi_fill++;
                end
            end
            else
            begin
                for (longint i = 0; i < count; i++)
                    if (longint'(page) + i < NPAGES)
                        pg_free[longint'(page) + i] = 1'b1;
                rover = (page > NPAGES) ? NPAGES : longint'(page);
            end
        end
        return r;
    endfunction

    // monitor
    always @(posedge clk)
    begin
        pfa_rsp_t w;
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("page_frame_allocator_unit_tb: FAIL");
            $finish;
        end
        else
        begin
            if (rst_n && rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    report("unexpected beat", PNB'(status), '0);
                end
                else
                begin
                    w = expected_rsps.pop_front();
                    if (status !== w.st)
                        report("status", PNB'(status), PNB'(w.st));
                    if (granted_page !== w.granted)
                        report("granted_page", granted_page, w.granted);
                end
            end
            if (rst_n && req_valid && req_ready)
            begin
                expected_rsps.push_back(allocate_or_free(action, page_number, page_count));
                accepted++;
            end
            if (rst_n && cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_PAGES)
                    tracked_pages = cfg_data[14:0];
                else if (cfg_index == CFG_BOUNDARY)
                    boundary = cfg_data;
            end
        end
    end

    // request driver
    always @(negedge clk)
    begin
        pfa_req_t it;
        if (rst_n)
        begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
            if (!req_valid || accepted == issued)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() == 0 ||
                         (pending_reqs[0].drain &&
                          (expected_rsps.size() != 0 || accepted != issued)))
                begin
                    req_valid <= 1'b0;
                end
                else
                begin
                    it = pending_reqs.pop_front();
                    action      <= it.act;
                    page_number <= it.page;
                    page_count  <= it.count;
                    req_valid   <= 1'b1;
                    issued++;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 20);
                        gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                    end
                end
            end
        end
    end

    function automatic logic [PNB-1:0] rand_page();
        return PNB'({$urandom, $urandom});
    endfunction

    task automatic add(input logic act, input logic [PNB-1:0] page,
                       input logic [14:0] count, input bit drain = 1'b0);
        pfa_req_t it;
        it.act = act;
        it.page = page;
        it.count = count;
        it.drain = drain;
        pending_reqs.push_back(it);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || accepted != issued ||
               expected_rsps.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [PNB-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_mix(input int n, input int pages, input logic [PNB-1:0] bnd);
        int r;
        int lim;
        lim = (pages > NPAGES) ? NPAGES : pages;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                add(1'b0, rand_page(), 15'($urandom_range(1, 8)), ($urandom_range(0, 99) == 0));
            else if (r < 72)
                add(1'b1, 36'($urandom_range(1, lim - 1)), 15'($urandom_range(2, 24)));
            else if (r < 77)
                add(1'b0, rand_page(), 15'($urandom_range(1, lim)));
            else if (r < 80)
                add(1'b1, rand_page(), 15'($urandom));
            else if (r < 83)
                add(1'($urandom_range(0, 1)), '0, 15'($urandom));
            else if (r < 88)
                add(1'b0, '0, '0);
            else if (r < 95)
                add(1'b1, (bnd == PAGE_MAX) ? PAGE_MAX : bnd + $urandom_range(0, 999), 15'd1);
            else
                add(1'b1, 36'($urandom_range(1, lim - 1)), 15'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_phase(input int pages, input logic [PNB-1:0] bnd, input int n,
                             input int gmax, input int spct);
        wait_idle();
        write_reg(CFG_PAGES, 36'({$urandom, $urandom} & 64'h7FFF_8000) | 36'(pages));
        write_reg(CFG_BOUNDARY, bnd);
        gap_max = gmax;
        stall_pct = spct;
        add(1'b1, 36'd1, 15'(pages > NPAGES ? NPAGES - 1 : pages - 1), 1'b1);
        random_mix(n, pages, bnd);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        action = 1'b0;
        page_number = '0;
        page_count = '0;
        rsp_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PAGES;
        cfg_data = '0;
        errors = 0;
        issued = 0;
        accepted = 0;
        cycles = 0;
        burst_left = 0;
        gap_left = 0;
        gap_max = 6;
        stall_pct = 30;
        rover = 0;
        hi_fill = 0;
        tracked_pages = RST_PAGES;
        boundary = 36'(RST_BOUNDARY);
        foreach (pg_free[i])
            pg_free[i] = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset settings
        add(1'b0, '0, 15'd1);
        add(1'b0, '0, 15'd0);
        add(1'b1, '0, 15'd5);
        add(1'b1, 36'd1, 15'd16383);
        add(1'b0, '0, 15'd16384);
        add(1'b0, '0, 15'd16383);
        add(1'b1, 36'd64, 15'd0);
        add(1'b1, 36'd20000, 15'd1);
        add(1'b0, '0, 15'd1);
        add(1'b1, PAGE_MAX, 15'd1);
        add(1'b0, PAGE_MAX, 15'd1);
        add(1'b1, 36'd16380, 15'd10);
        add(1'b1, 36'h8_0000_0000, 15'd16384);
        add(1'b0, '0, 15'h7FFF);
        add(1'b0, '0, 15'd3);
        add(1'b0, '0, 15'd2, 1'b1);
        wait_idle();
        write_reg(CFG_PAGES, 36'h7FFF);
        write_reg(CFG_BOUNDARY, '0);
        add(1'b1, 36'd5, 15'd1);
        add(1'b0, '0, 15'd1);
        add(1'b0, '0, 15'd16384);
        wait_idle();
        write_reg(CFG_PAGES, 36'd64);
        add(1'b0, '0, 15'd64);
        add(1'b0, '0, 15'd65);
        add(1'b1, 36'd10, 15'd4);
        add(1'b0, '0, 15'd4);

        run_phase(1024, 36'd2048, 20, 6, 30);
        run_phase(64, 36'd64, 20, 0, 0);
        run_phase(32767, 36'd16384, 20, 3, 60);

        // fill the high-page stack past full, then pop some
        wait_idle();
        write_reg(CFG_PAGES, 36'd512);
        write_reg(CFG_BOUNDARY, 36'd100);
        gap_max = 2;
        stall_pct = 10;
        for (int k = 0; k < 1026; k++)
            add(1'b1, 36'd100 + (rand_page() & 36'h0_FFFF_FFFF), 15'd1, (k == 600));
        for (int k = 0; k < 30; k++)
            add(1'($urandom_range(0, 1)), 36'd100 + $urandom_range(0, 9999), 15'd1);

        run_phase(4096, PAGE_MAX, 20, 10, 40);

        wait_idle();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("page_frame_allocator_unit_tb: PASS");
        else
            $display("page_frame_allocator_unit_tb: FAIL");
        $finish;
    end

endmodule

[sim.f]
design/pfa_pkg.sv
design/page_frame_allocator_unit.sv
design/pfa_checker.sv
bench/page_frame_allocator_unit_tb.sv
